/* rtl/iir_tdf2_pkg.sv */
`timescale 1ns / 1ps

package iir_tdf2_pkg;

   // default filter length, in taps
   localparam int TAPS_DEF = 4;

   // field widths
   localparam int OP_W     = 2;
   localparam int IDX_W    = 2;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 24;
   localparam int STATE_W  = 40;
   localparam int TAPS_W   = 3;

   // internal widths
   localparam int PBX_W  = COEF_W + SAMPLE_W;   // b*x, Q20.20
   localparam int PROD_W = 64;                  // a*y, Q24.40
   localparam int FRAC_SHIFT = 20;
   localparam int FB_W   = PROD_W - FRAC_SHIFT; // rounded a*y
   localparam int WIDE_W = FB_W + 2;            // room for part - fb

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // opcodes
   localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_B0   = 3'd0;
   localparam logic [2:0] REG_B1   = 3'd1;
   localparam logic [2:0] REG_B2   = 3'd2;
   localparam logic [2:0] REG_B3   = 3'd3;
   localparam logic [2:0] REG_A1   = 3'd4;
   localparam logic [2:0] REG_A2   = 3'd5;
   localparam logic [2:0] REG_A3   = 3'd6;
   localparam logic [2:0] REG_TAPS = 3'd7;

   // reset values
   localparam logic [COEF_W-1:0] COEF_B0_RST = 24'd1048576;
   localparam logic [TAPS_W-1:0] TAPS_RST    = 3'd1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULX,
      ST_YSUM,
      ST_MULA,
      ST_ROUND,
      ST_UPDATE,
      ST_DONE
   } seq_state_type;

   // stage strobes shared by the head and the cells
   typedef struct packed {
      logic mulx;
      logic ysum;
      logic mula;
      logic round;
      logic update;
   } cell_ctl_type;

   // clipping seen in the head
   typedef struct packed {
      logic y_clip;
      logic so_clip;
   } head_stat_type;

   // true when a wide value does not fit the state format
   function automatic logic state_clip(input logic [WIDE_W-1:0] v);
      logic [WIDE_W-STATE_W:0] top;
      begin
         top = v[WIDE_W-1:STATE_W-1];
         return !((&top) || !(|top));
      end
   endfunction

   // saturate a wide value to the state format
   function automatic logic [STATE_W-1:0] state_sat(input logic [WIDE_W-1:0] v);
      logic [STATE_W-1:0] res;
      begin
         if (!state_clip(v)) begin
            res = v[STATE_W-1:0];
         end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(STATE_W-1){1'b0}}};
         end else begin
            res = {1'b0, {(STATE_W-1){1'b1}}};
         end
         return res;
      end
   endfunction

endpackage

/* rtl/iir_tdf2_if.sv */
`timescale 1ns / 1ps

// request channel
interface iir_tdf2_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [iir_tdf2_pkg::OP_W-1:0]              opcode;
   logic [iir_tdf2_pkg::IDX_W-1:0]             entry_index;
   logic signed [iir_tdf2_pkg::SAMPLE_W-1:0]   sample_in;
   logic signed [iir_tdf2_pkg::STATE_W-1:0]    state_in;

   modport source (output valid, opcode, entry_index, sample_in, state_in, input ready);
   modport sink   (input valid, opcode, entry_index, sample_in, state_in, output ready);
endinterface

// result channel
interface iir_tdf2_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [iir_tdf2_pkg::SAMPLE_W-1:0]   sample_out;
   logic signed [iir_tdf2_pkg::STATE_W-1:0]    state_out;
   logic                                       saturated;

   modport source (output valid, sample_out, state_out, saturated, input ready);
   modport sink   (input valid, sample_out, state_out, saturated, output ready);
endinterface

/* rtl/iir_tdf2_head.sv */
`timescale 1ns / 1ps

module iir_tdf2_head (
   input  logic                                     clock,
   input  iir_tdf2_pkg::cell_ctl_type               ctl,
   input  logic                                     m_zero,
   input  logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [iir_tdf2_pkg::COEF_W-1:0]   coef_b0,
   input  logic signed [iir_tdf2_pkg::STATE_W-1:0]  s0,
   output logic signed [iir_tdf2_pkg::STATE_W-1:0]  y,
   output logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_y,
   output iir_tdf2_pkg::head_stat_type              stat
);

   localparam int SW = iir_tdf2_pkg::STATE_W;
   localparam int WW = iir_tdf2_pkg::WIDE_W;
   localparam int QW = SW + 1 - iir_tdf2_pkg::FRAC_SHIFT;
   localparam int OW = iir_tdf2_pkg::SAMPLE_W;

   logic signed [iir_tdf2_pkg::PBX_W-1:0] pb0_ff, pb0_in;
   logic signed [SW-1:0]                  y_ff, y_in;
   logic                                  yclip_ff, yclip_in;
   logic signed [OW-1:0]                  so_ff, so_in;
   logic                                  soclip_ff, soclip_in;
   logic [WW-1:0]                         ysum;
   logic [SW:0]                           yrnd;
   logic [QW-1:0]                         yq;
   logic [QW-OW:0]                        yq_top;

   // b0 * x
   assign pb0_in = coef_b0 * sample;

   // y = s0 + b0*x, saturated when the delay line is in use
   assign ysum     = {{(WW-SW){s0[SW-1]}}, s0} + {{(WW-SW){pb0_ff[SW-1]}}, pb0_ff};
   assign y_in     = m_zero ? pb0_ff : iir_tdf2_pkg::state_sat(ysum);
   assign yclip_in = !m_zero && iir_tdf2_pkg::state_clip(ysum);

   // output sample: round half up, then clip to 16 bits
   assign yrnd      = {y_ff[SW-1], y_ff} + (SW+1)'(1 << (iir_tdf2_pkg::FRAC_SHIFT - 1));
   assign yq        = yrnd[SW:iir_tdf2_pkg::FRAC_SHIFT];
   assign yq_top    = yq[QW-1:OW-1];
   assign soclip_in = !((&yq_top) || !(|yq_top));
   assign so_in     = !soclip_in ? yq[OW-1:0] :
                      (yq[QW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});

   // stage registers
   always_ff @(posedge clock) begin
      if (ctl.mulx) begin
         pb0_ff <= pb0_in;
      end
      if (ctl.ysum) begin
         y_ff     <= y_in;
         yclip_ff <= yclip_in;
      end
      if (ctl.mula) begin
         so_ff     <= so_in;
         soclip_ff <= soclip_in;
      end
   end

   assign y            = y_ff;
   assign sample_y     = so_ff;
   assign stat.y_clip  = yclip_ff;
   assign stat.so_clip = soclip_ff;

endmodule

/* rtl/iir_tdf2_cell.sv */
`timescale 1ns / 1ps

module iir_tdf2_cell (
   input  logic                                     clock,
   input  logic                                     reset,
   input  iir_tdf2_pkg::cell_ctl_type               ctl,
   input  logic                                     cell_en,
   input  logic                                     cell_last,
   input  logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [iir_tdf2_pkg::STATE_W-1:0]  y,
   input  logic signed [iir_tdf2_pkg::COEF_W-1:0]   coef_b,
   input  logic signed [iir_tdf2_pkg::COEF_W-1:0]   coef_a,
   input  logic signed [iir_tdf2_pkg::STATE_W-1:0]  next_entry,
   input  logic                                     wr_en,
   input  logic signed [iir_tdf2_pkg::STATE_W-1:0]  wr_data,
   output logic signed [iir_tdf2_pkg::STATE_W-1:0]  entry,
   output logic                                     clip
);

   localparam int SW = iir_tdf2_pkg::STATE_W;
   localparam int PW = iir_tdf2_pkg::PROD_W;
   localparam int FW = iir_tdf2_pkg::FB_W;
   localparam int WW = iir_tdf2_pkg::WIDE_W;

   logic signed [SW-1:0]                  entry_ff, entry_in;
   logic signed [iir_tdf2_pkg::PBX_W-1:0] pbx_ff, pbx_in;
   logic signed [PW-1:0]                  prod_ff, prod_in;
   logic signed [SW:0]                    part_ff, part_in;
   logic signed [FW-1:0]                  fb_ff, fb_in;
   logic signed [SW-1:0]                  nxt;
   logic [PW-1:0]                         rnd;
   logic [WW-1:0]                         tot;

   // neighbor entry, zero past the last used entry
   assign nxt = cell_last ? '0 : next_entry;

   // products and partial sum
   assign pbx_in  = coef_b * sample;
   assign prod_in = coef_a * y;
   assign part_in = $signed({nxt[SW-1], nxt}) + $signed({pbx_ff[SW-1], pbx_ff});

   // a*y rounded half up to the state format
   assign rnd   = prod_ff + PW'(1 << (iir_tdf2_pkg::FRAC_SHIFT - 1));
   assign fb_in = rnd[PW-1:iir_tdf2_pkg::FRAC_SHIFT];

   // new entry before saturation
   assign tot = {{(WW-SW-1){part_ff[SW]}}, part_ff} - {{(WW-FW){fb_ff[FW-1]}}, fb_ff};

   // entry update
   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in = wr_data;
      end else if (ctl.update && cell_en) begin
         entry_in = iir_tdf2_pkg::state_sat(tot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (ctl.mulx) begin
         pbx_ff <= pbx_in;
      end
      if (ctl.mula) begin
         prod_ff <= prod_in;
         part_ff <= part_in;
      end
      if (ctl.round) begin
         fb_ff <= fb_in;
      end
   end

   assign entry = entry_ff;
   assign clip  = ctl.update && cell_en && iir_tdf2_pkg::state_clip(tot);

endmodule

/* rtl/iir_filter_transposed_df2_top.sv */
`timescale 1ns / 1ps

// direct form II transposed iir filter, order up to TAPS-1
// req_chan carries one request: opcode, entry_index, sample_in, state_in.
// opcode filter runs one sample, write loads a delay entry, read returns one.
// rsp_chan returns exactly one result per request: sample_out, state_out and
// saturated. coefficients and taps_in_use are written over the apb port
// (register i at byte address 4*i); the user must do so only while the block
// is idle, the block itself does not enforce this. a filter request steps the
// sequencer through b*x, the y sum, a*y, rounding and the entry update, done in
// parallel by the row of cells, then the done state loads the output register.
// write, read and unknown opcodes go from idle straight to the done state.
// ready is high only while the sequencer is idle, so the next request is taken
// once the done state has loaded the output register; one request is in work
// at a time.
// the result register holds its value while rsp_chan.ready is low, and a new
// request may be taken meanwhile; the finished result waits in the last
// stage until the output register frees up.
// reset clears the delay line, loads coefficient defaults (b0 = 1.0, all
// others zero, one tap) and empties the output register.
module iir_filter_transposed_df2_top #(
   parameter int TAPS = iir_tdf2_pkg::TAPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   iir_tdf2_req_if.sink                          req_chan,
   iir_tdf2_rsp_if.source                        rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [iir_tdf2_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [iir_tdf2_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [iir_tdf2_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   localparam int DEPTH = TAPS - 1;
   localparam int CNT_W = $clog2(TAPS);
   localparam int SW    = iir_tdf2_pkg::STATE_W;
   localparam int CW    = iir_tdf2_pkg::COEF_W;
   localparam int DW    = iir_tdf2_pkg::CSR_DATA_W;
   localparam int TW    = iir_tdf2_pkg::TAPS_W;

   iir_tdf2_pkg::seq_state_type state_ff, state_in;

   logic [iir_tdf2_pkg::OP_W-1:0]            op_ff;
   logic [iir_tdf2_pkg::IDX_W-1:0]           idx_ff;
   logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [SW-1:0]                     wdata_ff;
   logic                                     flag_ff, flag_in;

   logic                                     rsp_valid_ff;
   logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SW-1:0]                     rsp_state_ff;
   logic                                     rsp_sat_ff;

   logic signed [CW-1:0] coef_b_ff [4];
   logic signed [CW-1:0] coef_a_ff [1:3];
   logic [TW-1:0]        taps_ff;

   logic                 accept, out_load, csr_wr;
   logic [2:0]           csr_idx;
   logic [TW-1:0]        taps_n;
   logic [CNT_W-1:0]     m_cnt;

   iir_tdf2_pkg::cell_ctl_type  ctl;
   iir_tdf2_pkg::head_stat_type hstat;

   logic signed [SW-1:0]                     entry_w [DEPTH+1];
   logic [DEPTH-1:0]                         clip_w;
   logic signed [SW-1:0]                     y_w;
   logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] so_w;
   logic signed [SW-1:0]                     rd_entry;

   // handshakes
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_load = (state_ff == iir_tdf2_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == iir_tdf2_pkg::ST_IDLE);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iir_tdf2_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl.mulx   = 1'b0;
      ctl.ysum   = 1'b0;
      ctl.mula   = 1'b0;
      ctl.round  = 1'b0;
      ctl.update = 1'b0;
      case (state_ff)
         iir_tdf2_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_chan.opcode == iir_tdf2_pkg::OP_FILTER) ?
                          iir_tdf2_pkg::ST_MULX : iir_tdf2_pkg::ST_DONE;
            end
         end
         iir_tdf2_pkg::ST_MULX: begin
            ctl.mulx = 1'b1;
            state_in = iir_tdf2_pkg::ST_YSUM;
         end
         iir_tdf2_pkg::ST_YSUM: begin
            ctl.ysum = 1'b1;
            state_in = iir_tdf2_pkg::ST_MULA;
         end
         iir_tdf2_pkg::ST_MULA: begin
            ctl.mula = 1'b1;
            state_in = iir_tdf2_pkg::ST_ROUND;
         end
         iir_tdf2_pkg::ST_ROUND: begin
            ctl.round = 1'b1;
            state_in  = iir_tdf2_pkg::ST_UPDATE;
         end
         iir_tdf2_pkg::ST_UPDATE: begin
            ctl.update = 1'b1;
            state_in   = iir_tdf2_pkg::ST_DONE;
         end
         iir_tdf2_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = iir_tdf2_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iir_tdf2_pkg::ST_IDLE;
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_chan.opcode;
         idx_ff   <= req_chan.entry_index;
         x_ff     <= req_chan.sample_in;
         wdata_ff <= req_chan.state_in;
      end
   end

   // clipping seen in the cells during this request
   assign flag_in = accept ? 1'b0 : (flag_ff | (|clip_w));

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
   end

   // taps in use clamped to 1..TAPS, entries in use is one less
   always_comb begin
      if (taps_ff == '0) begin
         taps_n = TW'(1);
      end else if (taps_ff > TW'(TAPS)) begin
         taps_n = TW'(TAPS);
      end else begin
         taps_n = taps_ff;
      end
   end

   assign m_cnt = CNT_W'(taps_n - TW'(1));

   // head: b0*x, y and the output sample
   iir_tdf2_head u_head (
      .clock    (clock),
      .ctl      (ctl),
      .m_zero   (m_cnt == '0),
      .sample   (x_ff),
      .coef_b0  (coef_b_ff[0]),
      .s0       (entry_w[0]),
      .y        (y_w),
      .sample_y (so_w),
      .stat     (hstat)
   );

   // row of delay cells, each takes its neighbor's entry
   assign entry_w[DEPTH] = '0;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      iir_tdf2_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cell_en    (CNT_W'(j) < m_cnt),
         .cell_last  (CNT_W'(j + 1) == m_cnt),
         .sample     (x_ff),
         .y          (y_w),
         .coef_b     (coef_b_ff[j + 1]),
         .coef_a     (coef_a_ff[j + 1]),
         .next_entry (entry_w[j + 1]),
         .wr_en      (out_load && (op_ff == iir_tdf2_pkg::OP_WRITE) &&
                      (idx_ff == iir_tdf2_pkg::IDX_W'(j))),
         .wr_data    (wdata_ff),
         .entry      (entry_w[j]),
         .clip       (clip_w[j])
      );
   end

   // entry read, zero past the delay line
   always_comb begin
      rd_entry = '0;
      for (int j = 0; j < DEPTH; j++) begin
         if (idx_ff == iir_tdf2_pkg::IDX_W'(j)) begin
            rd_entry = entry_w[j];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= (op_ff == iir_tdf2_pkg::OP_FILTER) ? so_w : '0;
         rsp_state_ff  <= (op_ff == iir_tdf2_pkg::OP_READ) ? rd_entry : '0;
         rsp_sat_ff    <= (op_ff == iir_tdf2_pkg::OP_FILTER) &&
                          (flag_ff || hstat.y_clip || hstat.so_clip);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.state_out  = rsp_state_ff;
   assign rsp_chan.saturated  = rsp_sat_ff;

   // register port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b_ff[0] <= iir_tdf2_pkg::COEF_B0_RST;
         coef_b_ff[1] <= '0;
         coef_b_ff[2] <= '0;
         coef_b_ff[3] <= '0;
         coef_a_ff[1] <= '0;
         coef_a_ff[2] <= '0;
         coef_a_ff[3] <= '0;
         taps_ff      <= iir_tdf2_pkg::TAPS_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            iir_tdf2_pkg::REG_B0:   coef_b_ff[0] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_B1:   coef_b_ff[1] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_B2:   coef_b_ff[2] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_B3:   coef_b_ff[3] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_A1:   coef_a_ff[1] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_A2:   coef_a_ff[2] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_A3:   coef_a_ff[3] <= pwdata[CW-1:0];
            iir_tdf2_pkg::REG_TAPS: taps_ff      <= pwdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   // register readback, coefficients sign extended
   always_comb begin
      case (csr_idx)
         iir_tdf2_pkg::REG_B0:   prdata = {{(DW-CW){coef_b_ff[0][CW-1]}}, coef_b_ff[0]};
         iir_tdf2_pkg::REG_B1:   prdata = {{(DW-CW){coef_b_ff[1][CW-1]}}, coef_b_ff[1]};
         iir_tdf2_pkg::REG_B2:   prdata = {{(DW-CW){coef_b_ff[2][CW-1]}}, coef_b_ff[2]};
         iir_tdf2_pkg::REG_B3:   prdata = {{(DW-CW){coef_b_ff[3][CW-1]}}, coef_b_ff[3]};
         iir_tdf2_pkg::REG_A1:   prdata = {{(DW-CW){coef_a_ff[1][CW-1]}}, coef_a_ff[1]};
         iir_tdf2_pkg::REG_A2:   prdata = {{(DW-CW){coef_a_ff[2][CW-1]}}, coef_a_ff[2]};
         iir_tdf2_pkg::REG_A3:   prdata = {{(DW-CW){coef_a_ff[3][CW-1]}}, coef_a_ff[3]};
         iir_tdf2_pkg::REG_TAPS: prdata = {{(DW-TW){1'b0}}, taps_ff};
         default:                prdata = '0;
      endcase
   end

endmodule

/* rtl/iir_tdf2_checker.sv */
`timescale 1ns / 1ps

module iir_tdf2_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_out,
   input logic signed [iir_tdf2_pkg::STATE_W-1:0]  state_out,
   input logic                                     saturated
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // no result appears in the cycle right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early after request");

   // a read result carries no sample and no clip flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (state_out != '0) |-> (sample_out == '0) && !saturated)
      else $error("read result mixed with filter fields");

endmodule

bind iir_filter_transposed_df2_top iir_tdf2_checker u_iir_tdf2_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .sample_out (rsp_chan.sample_out),
   .state_out  (rsp_chan.state_out),
   .saturated  (rsp_chan.saturated)
);

/* dv/tb_iir_filter_transposed_df2_top.sv */
`timescale 1ns / 1ps

module tb_iir_filter_transposed_df2_top;

   localparam int TAPS           = iir_tdf2_pkg::TAPS_DEF;
   localparam int DEPTH          = TAPS - 1;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 105;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   localparam int OP_W       = iir_tdf2_pkg::OP_W;
   localparam int IDX_W      = iir_tdf2_pkg::IDX_W;
   localparam int SAMPLE_W   = iir_tdf2_pkg::SAMPLE_W;
   localparam int STATE_W    = iir_tdf2_pkg::STATE_W;
   localparam int COEF_W     = iir_tdf2_pkg::COEF_W;
   localparam int TAPS_W     = iir_tdf2_pkg::TAPS_W;
   localparam int CSR_ADDR_W = iir_tdf2_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = iir_tdf2_pkg::CSR_DATA_W;
   localparam int FRAC_SHIFT = iir_tdf2_pkg::FRAC_SHIFT;

   localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
   localparam longint            STATE_MAX  = 64'sd549755813887;
   localparam longint            STATE_MIN  = -STATE_MAX - 64'sd1;
   localparam longint            ROUND_HALF = 64'sd524288;
   localparam logic [COEF_W-1:0] COEF_MAX   = 24'h7FFFFF;
   localparam logic [COEF_W-1:0] COEF_MIN   = 24'h800000;

   // coefficient flavors used per phase
   typedef enum int {
      MODE_WIDE,
      MODE_STABLE,
      MODE_FIR,
      MODE_EDGE
   } coef_mode_type;

   typedef struct packed {
      logic [OP_W-1:0]            opcode;
      logic [IDX_W-1:0]           entry_index;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic signed [STATE_W-1:0]  state_in;
   } request_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic signed [STATE_W-1:0]  state_out;
      logic                       saturated;
   } result_type;

   // mirror of the filter: coefficients, delay line and expected results
   class iir_scoreboard_type;
      logic signed [COEF_W-1:0]  fwd_coef [TAPS];
      logic signed [COEF_W-1:0]  fb_coef [TAPS];
      logic [TAPS_W-1:0]         tap_setting;
      logic signed [STATE_W-1:0] delay_reg [DEPTH];
      result_type                pending_results [$];
      int unsigned               error_count;
      int unsigned               result_count;
      int unsigned               clip_count;
      int unsigned               op_count [4];

      function new();
         foreach (fwd_coef[i]) begin
            fwd_coef[i] = '0;
            fb_coef[i]  = '0;
         end
         fwd_coef[0] = iir_tdf2_pkg::COEF_B0_RST;
         tap_setting = iir_tdf2_pkg::TAPS_RST;
         foreach (delay_reg[i]) delay_reg[i] = '0;
         foreach (op_count[i]) op_count[i] = 0;
         error_count  = 0;
         result_count = 0;
         clip_count   = 0;
      endfunction

      function longint limit_to(input longint v, input longint lo, input longint hi,
                                inout bit clipped);
         if (v > hi) begin
            clipped = 1'b1;
            return hi;
         end
         if (v < lo) begin
            clipped = 1'b1;
            return lo;
         end
         return v;
      endfunction

      function void set_register(logic [2:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            iir_tdf2_pkg::REG_B0, iir_tdf2_pkg::REG_B1,
            iir_tdf2_pkg::REG_B2, iir_tdf2_pkg::REG_B3:
               fwd_coef[idx] = value[COEF_W-1:0];
            iir_tdf2_pkg::REG_A1, iir_tdf2_pkg::REG_A2, iir_tdf2_pkg::REG_A3:
               fb_coef[idx - iir_tdf2_pkg::REG_A1 + 1] = value[COEF_W-1:0];
            iir_tdf2_pkg::REG_TAPS:
               tap_setting = value[TAPS_W-1:0];
            default: ;
         endcase
      endfunction

      // one sample through the transposed structure
      function result_type run_filter(logic signed [SAMPLE_W-1:0] x);
         result_type r;
         longint     y;
         longint     fb;
         longint     nxt;
         int         n;
         int         m;
         bit         clipped;
         r = '0;
         clipped = 1'b0;
         n = int'(tap_setting);
         if (n < 1) n = 1;
         if (n > TAPS) n = TAPS;
         m = n - 1;
         if (m == 0) begin
            // plain gain, delay line untouched
            y = longint'(fwd_coef[0]) * longint'(x);
         end else begin
            y = limit_to(longint'(delay_reg[0]) + longint'(fwd_coef[0]) * longint'(x),
                         STATE_MIN, STATE_MAX, clipped);
            for (int j = 0; j < m; j++) begin
               fb  = (longint'(fb_coef[j + 1]) * y + ROUND_HALF) >>> FRAC_SHIFT;
               nxt = (j + 1 < m) ? longint'(delay_reg[j + 1]) : 64'sd0;
               delay_reg[j] = STATE_W'(limit_to(nxt - fb + longint'(fwd_coef[j + 1]) *
                                                longint'(x), STATE_MIN, STATE_MAX, clipped));
            end
         end
         r.sample_out = SAMPLE_W'(limit_to((y + ROUND_HALF) >>> FRAC_SHIFT,
                                           -64'sd32768, 64'sd32767, clipped));
         r.saturated = clipped;
         return r;
      endfunction

      function void note_request(request_type item);
         result_type want;
         want = '0;
         op_count[item.opcode]++;
         case (item.opcode)
            iir_tdf2_pkg::OP_FILTER: want = run_filter(item.sample_in);
            iir_tdf2_pkg::OP_WRITE: begin
               if (item.entry_index < DEPTH) delay_reg[item.entry_index] = item.state_in;
            end
            iir_tdf2_pkg::OP_READ: begin
               if (item.entry_index < DEPTH) want.state_out = delay_reg[item.entry_index];
            end
            default: ;
         endcase
         if (want.saturated) clip_count++;
         pending_results = {pending_results, want};
      endfunction

      function void check_result(result_type got);
         result_type want;
         result_count++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d / %0d / %0b",
                     $time, got.sample_out, got.state_out, got.saturated);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.sample_out !== want.sample_out) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want.sample_out, got.sample_out);
            error_count++;
         end
         if (got.state_out !== want.state_out) begin
            $display("%0t: state_out mismatch, expected %0d, actual %0d",
                     $time, want.state_out, got.state_out);
            error_count++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, want.saturated, got.saturated);
            error_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   iir_tdf2_req_if req_chan ();
   iir_tdf2_rsp_if rsp_chan ();

   iir_scoreboard_type iir_sb;
   int                 req_burst_left = 0;
   int                 rsp_burst_left = 0;
   int                 setting_count  = 0;
   int                 taps_plan [RANDOM_PHASES] = '{4, 3, 2, 0, 4, 7, 1, 5, 3, 6};

   iir_filter_transposed_df2_top #(
      .TAPS(TAPS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // wait before an item: mostly random, sometimes a run with no wait
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic signed [STATE_W-1:0] draw_state();
      logic [63:0] r;
      r = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) return r[STATE_W-1:0];
      return {{(STATE_W - 35){r[34]}}, r[34:0]};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] draw_coef(coef_mode_type mode, bit feedback);
      logic [CSR_DATA_W-1:0] word;
      logic [COEF_W-1:0]     coef;
      word = $urandom;
      case (mode)
         MODE_WIDE: coef = COEF_W'($urandom);
         MODE_STABLE: begin
            // feedback of at most 0.25 in magnitude each keeps the poles inside the unit circle
            if (feedback) coef = COEF_W'(int'($urandom_range(0, 524288)) - 262144);
            else          coef = COEF_W'(int'($urandom_range(0, 2097152)) - 1048576);
         end
         MODE_FIR: begin
            if (feedback) coef = '0;
            else          coef = COEF_W'(int'($urandom_range(0, 4194304)) - 2097152);
         end
         default: begin
            case ($urandom_range(0, 2))
               0:       coef = COEF_MAX;
               1:       coef = COEF_MIN;
               default: coef = '0;
            endcase
         end
      endcase
      return {word[CSR_DATA_W-1:COEF_W], coef};
   endfunction

   // apb write: setup then access, mirrored at the accepting edge
   task automatic write_register(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      iir_sb.set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // one request, held until accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [STATE_W-1:0] s);
      int          gap;
      request_type item;
      gap = draw_wait(req_burst_left);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.opcode      <= op;
      req_chan.entry_index <= idx;
      req_chan.sample_in   <= x;
      req_chan.state_in    <= s;
      req_chan.valid       <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      item.opcode      = op;
      item.entry_index = idx;
      item.sample_in   = x;
      item.state_in    = s;
      iir_sb.note_request(item);
   endtask

   // stop requesting and let every result come back
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (iir_sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // result side with random stalls
   initial begin : result_sink
      int         stall;
      result_type got;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(rsp_burst_left);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         got.sample_out = rsp_chan.sample_out;
         got.state_out  = rsp_chan.state_out;
         got.saturated  = rsp_chan.saturated;
         iir_sb.check_result(got);
         @(negedge clock);
      end
   end

   // ends the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_iir_filter_transposed_df2_top: errors");
      $finish;
   end

   initial begin : stimulus
      int                         pick;
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] x;
      coef_mode_type              mode;
      iir_sb = new();
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = iir_tdf2_pkg::OP_FILTER;
      req_chan.entry_index = '0;
      req_chan.sample_in   = '0;
      req_chan.state_in    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: unity gain, one tap
      setting_count++;
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd0, 16'sh7FFF, '0);
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd3, 16'sh8000, '1);
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd1, 16'sh0000, '0);
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd2, 16'sh0001, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd0, '0, '0);
      send_request(iir_tdf2_pkg::OP_WRITE, 2'd0, '0, 40'sh7FFFFFFFFF);
      send_request(iir_tdf2_pkg::OP_WRITE, 2'd1, '1, 40'sh8000000000);
      send_request(iir_tdf2_pkg::OP_WRITE, 2'd2, '0, 40'sh5A5A5A5A5A);
      // index past the delay line is ignored
      send_request(iir_tdf2_pkg::OP_WRITE, 2'd3, '0, '1);
      send_request(iir_tdf2_pkg::OP_READ, 2'd0, '0, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd1, '0, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd2, '0, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd3, '0, '1);
      send_request(OP_UNUSED, 2'd3, 16'sh7FFF, '1);
      // gain mode leaves the delay line alone
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd0, 16'shFFFF, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd2, '0, '0);
      drain_results();

      // extreme coefficients, full order, saturating state
      setting_count++;
      for (int k = 0; k < 4; k++) write_register(3'(k), {8'hA5, COEF_MAX});
      write_register(iir_tdf2_pkg::REG_A1, {8'h5A, COEF_MIN});
      write_register(iir_tdf2_pkg::REG_A2, {8'h5A, COEF_MIN});
      write_register(iir_tdf2_pkg::REG_A3, {8'h5A, COEF_MIN});
      write_register(iir_tdf2_pkg::REG_TAPS, 32'd4);
      send_request(iir_tdf2_pkg::OP_WRITE, 2'd0, '0, 40'sh7FFFFFFFFF);
      send_request(iir_tdf2_pkg::OP_WRITE, 2'd1, '0, 40'sh7FFFFFFFFF);
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd0, 16'sh7FFF, '0);
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd0, 16'sh8000, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd0, '0, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd1, '0, '0);
      send_request(iir_tdf2_pkg::OP_READ, 2'd2, '0, '0);
      send_request(iir_tdf2_pkg::OP_FILTER, 2'd0, 16'sh0000, '0);
      drain_results();

      // random phases, each with a fresh coefficient set
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         setting_count++;
         mode = coef_mode_type'(phase % 4);
         for (int k = 0; k < 7; k++) begin
            write_register(3'(k), draw_coef(mode, k >= int'(iir_tdf2_pkg::REG_A1)));
         end
         write_register(iir_tdf2_pkg::REG_TAPS,
                        {8'($urandom_range(0, 255)), 21'd0, 3'(taps_plan[phase])});
         // load an initial state, then run samples with reads and rewrites mixed in
         for (int k = 0; k < DEPTH; k++) begin
            send_request(iir_tdf2_pkg::OP_WRITE, IDX_W'(k), SAMPLE_W'($urandom),
                         draw_state());
         end
         repeat (PHASE_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      op = iir_tdf2_pkg::OP_FILTER;
            else if (pick < 80) op = iir_tdf2_pkg::OP_WRITE;
            else if (pick < 94) op = iir_tdf2_pkg::OP_READ;
            else                op = OP_UNUSED;
            case ($urandom_range(0, 9))
               0:          x = 16'sh7FFF;
               1:          x = 16'sh8000;
               2, 3, 4, 5: x = SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
               default:    x = SAMPLE_W'($urandom);
            endcase
            send_request(op, IDX_W'($urandom_range(0, 3)), x, draw_state());
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d filter, %0d entry write, %0d entry read, %0d unknown opcode requests",
               iir_sb.op_count[iir_tdf2_pkg::OP_FILTER], iir_sb.op_count[iir_tdf2_pkg::OP_WRITE],
               iir_sb.op_count[iir_tdf2_pkg::OP_READ], iir_sb.op_count[OP_UNUSED]);
      $display("over %0d coefficient settings; %0d results checked, %0d expected to clip",
               setting_count, iir_sb.result_count, iir_sb.clip_count);
      if (iir_sb.error_count == 0 && iir_sb.pending_results.size() == 0) begin
         $display("tb_iir_filter_transposed_df2_top: clean");
      end else begin
         $display("tb_iir_filter_transposed_df2_top: errors");
      end
      $finish;
   end

endmodule
